// ===== hw/rtl/wdmd_pkg.sv =====
// Shared constants, codes and types for the window deviation motion detector.
// No dependencies; used by window_deviation_motion_detector_core.
`timescale 1ns / 1ps

package wdmd_pkg;

    // Window storage
    localparam int WINDOW_DEPTH = 32;
    localparam int SAMPLE_BITS  = 24;
    localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
    localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);

    // Sum of a full window and the divider that splits it
    localparam int SUM_W        = SAMPLE_BITS + $clog2(WINDOW_DEPTH + 1);
    localparam int DIV_RADIX_W  = 4;
    localparam int DIV_STEPS    = (SUM_W + DIV_RADIX_W - 1) / DIV_RADIX_W;
    localparam int DIV_W        = DIV_STEPS * DIV_RADIX_W;
    localparam int DIV_CNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    // Port widths
    localparam int MAG_W        = 24;
    localparam int OUT_W        = 24;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int WL_W         = 6;
    localparam int THR_W        = 16;
    localparam int COUNT_W      = 16;

    // Register reset values
    localparam logic [WL_W-1:0]    WL_RESET   = WL_W'(32);
    localparam logic [THR_W-1:0]   THR_RESET  = THR_W'(300);
    localparam logic [COUNT_W-1:0] HOLD_RESET = COUNT_W'(1000);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUIET_HOLD       = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PUT,
        ST_DIVM,
        ST_DEV,
        ST_DIVD,
        ST_FIN
    } state_t;

endpackage

// ===== hw/rtl/window_deviation_motion_detector_core.sv =====
// Each request shifts the window, divides its sum for the mean, sums the distances from the mean
// and divides that sum; one request is taken at a time (in_stall is high outside the idle state),
// the next is taken in the cycle after the result loads, and a stalled result holds the finishing
// state. The window memory sets the two passes (shift is skipped for L = 1); the divider is radix-16.
// Reset (rst_n, async, active low) empties the window to zeros through per-entry valid
// bits, clears the quiet counter and moving flag and loads register defaults at once.
`timescale 1ns / 1ps

module window_deviation_motion_detector_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [wdmd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wdmd_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Sample request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [wdmd_pkg::MAG_W-1:0]           magnitude,
    // Result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 is_moving,
    output logic [wdmd_pkg::OUT_W-1:0]           deviation,
    output logic [wdmd_pkg::OUT_W-1:0]           window_mean
);

    // Configuration registers
    logic [wdmd_pkg::WL_W-1:0]      wl_reg;
    logic [wdmd_pkg::THR_W-1:0]     thr_reg;
    logic [wdmd_pkg::COUNT_W-1:0]   hold_reg;

    // Sequencer and datapath registers
    wdmd_pkg::state_t               state_reg, state_next;
    logic [wdmd_pkg::SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [wdmd_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [wdmd_pkg::LEN_W-1:0]     idx_reg, idx_next;
    logic                           pend_reg, pend_next;
    logic [wdmd_pkg::ADDR_W-1:0]    pend_addr_reg, pend_addr_next;
    logic [wdmd_pkg::SUM_W-1:0]     sum_reg, sum_next;
    logic [wdmd_pkg::SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic [wdmd_pkg::SAMPLE_BITS-1:0] dev_reg, dev_next;
    logic [wdmd_pkg::COUNT_W-1:0]   quiet_reg, quiet_next;
    logic                           moving_reg, moving_next;

    // Divider registers
    logic [wdmd_pkg::DIV_W-1:0]     div_q_reg, div_q_next;
    logic [wdmd_pkg::LEN_W-1:0]     div_r_reg, div_r_next;
    logic [wdmd_pkg::DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [wdmd_pkg::DIV_W-1:0]     div_q_step;
    logic [wdmd_pkg::LEN_W-1:0]     div_r_step;
    logic                           div_last;

    // Output register
    logic                           out_valid_reg, out_valid_next;
    logic                           out_moving_reg, out_moving_next;
    logic [wdmd_pkg::OUT_W-1:0]     out_dev_reg, out_dev_next;
    logic [wdmd_pkg::OUT_W-1:0]     out_mean_reg, out_mean_next;

    // Window memory
    logic [wdmd_pkg::SAMPLE_BITS-1:0] mem [wdmd_pkg::WINDOW_DEPTH];
    logic [wdmd_pkg::WINDOW_DEPTH-1:0] vld_reg;
    logic                           mem_we;
    logic [wdmd_pkg::ADDR_W-1:0]    mem_wa;
    logic [wdmd_pkg::SAMPLE_BITS-1:0] mem_wd;
    logic [wdmd_pkg::ADDR_W-1:0]    mem_ra;
    logic [wdmd_pkg::SAMPLE_BITS-1:0] rd_data_reg;
    logic                           rd_vld_reg;
    logic [wdmd_pkg::SAMPLE_BITS-1:0] rd_value;
    logic [wdmd_pkg::SAMPLE_BITS-1:0] abs_diff;

    logic                           in_take;
    logic                           out_take;
    logic                           out_free;
    logic [wdmd_pkg::LEN_W-1:0]     eff_len;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Clamp the window length to 1..WINDOW_DEPTH
    always_comb
    begin
        if (wl_reg == '0)
        begin
            eff_len = wdmd_pkg::LEN_W'(1);
        end
        else if (int'(wl_reg) > wdmd_pkg::WINDOW_DEPTH)
        begin
            eff_len = wdmd_pkg::LEN_W'(wdmd_pkg::WINDOW_DEPTH);
        end
        else
        begin
            eff_len = wdmd_pkg::LEN_W'(wl_reg);
        end
    end

    // Take configuration writes; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg   <= wdmd_pkg::WL_RESET;
            thr_reg  <= wdmd_pkg::THR_RESET;
            hold_reg <= wdmd_pkg::HOLD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wdmd_pkg::CFG_WINDOW_LENGTH:    wl_reg   <= cfg_data[wdmd_pkg::WL_W-1:0];
                wdmd_pkg::CFG_MOTION_THRESHOLD: thr_reg  <= cfg_data[wdmd_pkg::THR_W-1:0];
                wdmd_pkg::CFG_QUIET_HOLD:       hold_reg <= cfg_data[wdmd_pkg::COUNT_W-1:0];
                default:                        ;
            endcase
        end
    end

    // Window memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // Entry valid bits; an entry never written reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                vld_reg[mem_wa] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[mem_ra];
        end
    end

    assign rd_value = rd_vld_reg ? rd_data_reg : '0;
    assign abs_diff = (rd_value >= mean_reg) ? (rd_value - mean_reg) : (mean_reg - rd_value);

    // Divider: four restoring steps per cycle, divisor is the window length
    always_comb
    begin
        logic [wdmd_pkg::LEN_W:0]   r;
        logic [wdmd_pkg::DIV_W-1:0] q;
        r = {1'b0, div_r_reg};
        q = div_q_reg;
        for (int j = 0; j < wdmd_pkg::DIV_RADIX_W; j++)
        begin
            r = {r[wdmd_pkg::LEN_W-1:0], q[wdmd_pkg::DIV_W-1]};
            q = {q[wdmd_pkg::DIV_W-2:0], 1'b0};
            if (r >= {1'b0, len_reg})
            begin
                r    = r - {1'b0, len_reg};
                q[0] = 1'b1;
            end
        end
        div_r_step = r[wdmd_pkg::LEN_W-1:0];
        div_q_step = q;
    end

    assign div_last = (div_cnt_reg == wdmd_pkg::DIV_CNT_W'(wdmd_pkg::DIV_STEPS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wdmd_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (eff_len == wdmd_pkg::LEN_W'(1)) ? wdmd_pkg::ST_PUT
                                                                 : wdmd_pkg::ST_SHIFT;
                end
            end
            wdmd_pkg::ST_SHIFT:
            begin
                if (idx_reg == len_reg - wdmd_pkg::LEN_W'(1) && pend_reg)
                begin
                    state_next = wdmd_pkg::ST_PUT;
                end
            end
            wdmd_pkg::ST_PUT:
            begin
                state_next = wdmd_pkg::ST_DIVM;
            end
            wdmd_pkg::ST_DIVM:
            begin
                if (div_last)
                begin
                    state_next = wdmd_pkg::ST_DEV;
                end
            end
            wdmd_pkg::ST_DEV:
            begin
                if (idx_reg == len_reg && pend_reg)
                begin
                    state_next = wdmd_pkg::ST_DIVD;
                end
            end
            wdmd_pkg::ST_DIVD:
            begin
                if (div_last)
                begin
                    state_next = wdmd_pkg::ST_FIN;
                end
            end
            wdmd_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = wdmd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wdmd_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        logic [wdmd_pkg::COUNT_W-1:0] qc;
        logic                         mv;

        sample_next     = sample_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        sum_next        = sum_reg;
        mean_next       = mean_reg;
        dev_next        = dev_reg;
        quiet_next      = quiet_reg;
        moving_next     = moving_reg;
        div_q_next      = div_q_reg;
        div_r_next      = div_r_reg;
        div_cnt_next    = div_cnt_reg;
        out_valid_next  = out_take ? 1'b0 : out_valid_reg;
        out_moving_next = out_moving_reg;
        out_dev_next    = out_dev_reg;
        out_mean_next   = out_mean_reg;
        mem_we          = 1'b0;
        mem_wa          = pend_addr_reg;
        mem_wd          = rd_value;
        mem_ra          = idx_reg[wdmd_pkg::ADDR_W-1:0];
        in_stall        = (state_reg != wdmd_pkg::ST_IDLE);
        qc              = quiet_reg;
        mv              = moving_reg;

        case (state_reg)
            wdmd_pkg::ST_IDLE:
            begin
                // Capture the request and the window length it works on
                if (in_take)
                begin
                    sample_next = wdmd_pkg::SAMPLE_BITS'(magnitude);
                    len_next    = eff_len;
                    idx_next    = '0;
                    sum_next    = '0;
                end
            end
            wdmd_pkg::ST_SHIFT:
            begin
                // Move entry i+1 down to entry i and sum the moved values
                if (pend_reg)
                begin
                    mem_we   = 1'b1;
                    sum_next = sum_reg + wdmd_pkg::SUM_W'(rd_value);
                end
                mem_ra = idx_reg[wdmd_pkg::ADDR_W-1:0] + wdmd_pkg::ADDR_W'(1);
                if (idx_reg != len_reg - wdmd_pkg::LEN_W'(1))
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[wdmd_pkg::ADDR_W-1:0];
                    idx_next       = idx_reg + wdmd_pkg::LEN_W'(1);
                end
            end
            wdmd_pkg::ST_PUT:
            begin
                // Place the new sample at the top of the window, start the mean division
                mem_we       = 1'b1;
                mem_wa       = wdmd_pkg::ADDR_W'(len_reg - wdmd_pkg::LEN_W'(1));
                mem_wd       = sample_reg;
                div_q_next   = wdmd_pkg::DIV_W'(sum_reg + wdmd_pkg::SUM_W'(sample_reg));
                div_r_next   = '0;
                div_cnt_next = '0;
            end
            wdmd_pkg::ST_DIVM:
            begin
                div_q_next   = div_q_step;
                div_r_next   = div_r_step;
                div_cnt_next = div_cnt_reg + wdmd_pkg::DIV_CNT_W'(1);
                if (div_last)
                begin
                    mean_next = wdmd_pkg::SAMPLE_BITS'(div_q_step);
                    sum_next  = '0;
                    idx_next  = '0;
                end
            end
            wdmd_pkg::ST_DEV:
            begin
                // Read every entry and add its distance from the mean
                if (pend_reg)
                begin
                    sum_next = sum_reg + wdmd_pkg::SUM_W'(abs_diff);
                end
                if (idx_reg != len_reg)
                begin
                    pend_next = 1'b1;
                    idx_next  = idx_reg + wdmd_pkg::LEN_W'(1);
                end
                else if (pend_reg)
                begin
                    div_q_next   = wdmd_pkg::DIV_W'(sum_reg + wdmd_pkg::SUM_W'(abs_diff));
                    div_r_next   = '0;
                    div_cnt_next = '0;
                end
            end
            wdmd_pkg::ST_DIVD:
            begin
                div_q_next   = div_q_step;
                div_r_next   = div_r_step;
                div_cnt_next = div_cnt_reg + wdmd_pkg::DIV_CNT_W'(1);
                if (div_last)
                begin
                    dev_next = wdmd_pkg::SAMPLE_BITS'(div_q_step);
                end
            end
            wdmd_pkg::ST_FIN:
            begin
                // Update the quiet counter and moving flag, load the result
                if (out_free)
                begin
                    if (wdmd_pkg::SUM_W'(dev_reg) < wdmd_pkg::SUM_W'(thr_reg))
                    begin
                        if (qc != '1)
                        begin
                            qc = qc + wdmd_pkg::COUNT_W'(1);
                        end
                    end
                    else
                    begin
                        qc = '0;
                        mv = 1'b1;
                    end
                    if (qc > hold_reg)
                    begin
                        qc = '0;
                        mv = 1'b0;
                    end
                    quiet_next      = qc;
                    moving_next     = mv;
                    out_valid_next  = 1'b1;
                    out_moving_next = mv;
                    out_dev_next    = wdmd_pkg::OUT_W'(dev_reg);
                    out_mean_next   = wdmd_pkg::OUT_W'(mean_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wdmd_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            div_cnt_reg   <= '0;
            quiet_reg     <= '0;
            moving_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
            div_cnt_reg   <= div_cnt_next;
            quiet_reg     <= quiet_next;
            moving_reg    <= moving_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        len_reg        <= len_next;
        pend_addr_reg  <= pend_addr_next;
        sum_reg        <= sum_next;
        mean_reg       <= mean_next;
        dev_reg        <= dev_next;
        div_q_reg      <= div_q_next;
        div_r_reg      <= div_r_next;
        out_moving_reg <= out_moving_next;
        out_dev_reg    <= out_dev_next;
        out_mean_reg   <= out_mean_next;
    end

    assign out_valid   = out_valid_reg;
    assign is_moving   = out_moving_reg;
    assign deviation   = out_dev_reg;
    assign window_mean = out_mean_reg;

    // A new result appears only out of the finishing state
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == wdmd_pkg::ST_FIN))
        else $error("result loaded outside the finishing state");

    // Read data is pending only during the two memory passes
    a_pend_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == wdmd_pkg::ST_SHIFT || state_reg == wdmd_pkg::ST_DEV))
        else $error("memory read pending outside a window pass");

    // Pass index stays within the captured window length
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wdmd_pkg::ST_SHIFT || state_reg == wdmd_pkg::ST_DEV)
        |-> idx_reg <= len_reg)
        else $error("window pass index beyond window length");

    // The mean division runs its full step count before the deviation pass
    a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wdmd_pkg::ST_DEV && $past(state_reg == wdmd_pkg::ST_DIVM))
        |-> $past(div_last))
        else $error("mean division left early");

endmodule

// ===== tb/sv/window_deviation_motion_detector_core_test.sv =====
// Self-checking testbench for window_deviation_motion_detector_core: directed and random
// magnitude samples, register writes between phases, random gaps on both channels.
// Depends on wdmd_pkg and the core RTL only.
`timescale 1ns / 1ps

module window_deviation_motion_detector_core_test;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int MAX_GAP       = 15;
    localparam int DRAIN_CYCLES  = 2 * wdmd_pkg::WINDOW_DEPTH + 20;
    // Index that decodes to no register
    localparam logic [wdmd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        logic                       is_moving;
        logic [wdmd_pkg::OUT_W-1:0] deviation;
        logic [wdmd_pkg::OUT_W-1:0] window_mean;
    } motion_result_t;

    // Ports
    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [wdmd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [wdmd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [wdmd_pkg::MAG_W-1:0]       magnitude = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             is_moving;
    logic [wdmd_pkg::OUT_W-1:0]       deviation;
    logic [wdmd_pkg::OUT_W-1:0]       window_mean;

    // Predicted detector state and register copies
    logic [wdmd_pkg::MAG_W-1:0]       window_samples [wdmd_pkg::WINDOW_DEPTH];
    logic [wdmd_pkg::COUNT_W-1:0]     quiet_cnt = '0;
    logic                             moving = 1'b0;
    logic [wdmd_pkg::WL_W-1:0]        wl_reg = wdmd_pkg::WL_RESET;
    logic [wdmd_pkg::THR_W-1:0]       thr_reg = wdmd_pkg::THR_RESET;
    logic [wdmd_pkg::COUNT_W-1:0]     hold_reg = wdmd_pkg::HOLD_RESET;

    motion_result_t         pending_results [$];

    // Bookkeeping
    int  mismatches = 0;
    int  samples_sent = 0;
    int  results_checked = 0;
    int  reg_writes = 0;
    int  flag_sets = 0;
    int  flag_clears = 0;
    int  cycle_count = 0;
    bit  gaps_on = 1'b1;
    bit  draw_stall = 1'b1;
    int  stall_left = 0;

    window_deviation_motion_detector_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .magnitude   (magnitude),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .is_moving   (is_moving),
        .deviation   (deviation),
        .window_mean (window_mean)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Shift in one sample, then compute mean, deviation and the motion flag
    function automatic motion_result_t advance_window(input logic [wdmd_pkg::MAG_W-1:0] mag);
        motion_result_t res;
        int unsigned    len;
        int unsigned    i;
        logic [31:0]    total;
        logic [31:0]    spread;
        logic [31:0]    avg;
        logic [31:0]    dev;
        logic           was_moving;
        len = 32'(wl_reg);
        if (len == 0)
            len = 1;
        if (len > wdmd_pkg::WINDOW_DEPTH)
            len = wdmd_pkg::WINDOW_DEPTH;
        for (i = 0; i + 1 < len; i++)
            window_samples[i] = window_samples[i + 1];
        window_samples[len - 1] = mag;
        total = '0;
        for (i = 0; i < len; i++)
            total += 32'(window_samples[i]);
        avg = total / len;
        spread = '0;
        for (i = 0; i < len; i++)
            spread += (32'(window_samples[i]) >= avg) ? 32'(window_samples[i]) - avg
                                                       : avg - 32'(window_samples[i]);
        dev = spread / len;
        was_moving = moving;
        if (dev < 32'(thr_reg))
        begin
            if (quiet_cnt != {wdmd_pkg::COUNT_W{1'b1}})
                quiet_cnt++;
        end
        else
        begin
            quiet_cnt = '0;
            moving = 1'b1;
        end
        if (quiet_cnt > hold_reg)
        begin
            quiet_cnt = '0;
            moving = 1'b0;
        end
        if (moving && !was_moving)
            flag_sets++;
        if (!moving && was_moving)
            flag_clears++;
        res.is_moving   = moving;
        res.deviation   = dev[wdmd_pkg::OUT_W-1:0];
        res.window_mean = avg[wdmd_pkg::OUT_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
                 results_checked, what, got, want);
        mismatches++;
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        motion_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, window_mean", 32'(window_mean), 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (is_moving !== want.is_moving)
                    report_mismatch("is_moving", 32'(is_moving), 32'(want.is_moving));
                if (deviation !== want.deviation)
                    report_mismatch("deviation", 32'(deviation), 32'(want.deviation));
                if (window_mean !== want.window_mean)
                    report_mismatch("window_mean", 32'(window_mean), 32'(want.window_mean));
            end
            results_checked++;
            draw_stall = 1'b1;
        end
    end

    // Hold off each result for a random number of cycles while it is offered
    always @(negedge clk)
    begin
        if (draw_stall)
        begin
            stall_left = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
            draw_stall = 1'b0;
        end
        if (stall_left > 0 && out_valid)
            stall_left--;
        out_stall <= (stall_left > 0);
    end

    // Send one sample request; starts and ends at a falling edge
    task automatic send_sample(input logic [wdmd_pkg::MAG_W-1:0] mag);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        magnitude <= mag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(advance_window(mag));
        samples_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic settle_block();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write one register once nothing is in flight
    task automatic write_reg(input logic [wdmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wdmd_pkg::CFG_DATA_W-1:0] val);
        settle_block();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            wdmd_pkg::CFG_WINDOW_LENGTH:    wl_reg   = val[wdmd_pkg::WL_W-1:0];
            wdmd_pkg::CFG_MOTION_THRESHOLD: thr_reg  = val[wdmd_pkg::THR_W-1:0];
            wdmd_pkg::CFG_QUIET_HOLD:       hold_reg = val[wdmd_pkg::COUNT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Reset registers: full window, extreme samples
    task automatic test_reset_defaults();
        send_sample('0);
        send_sample({wdmd_pkg::MAG_W{1'b1}});
        send_sample('0);
        send_sample(24'h800001);
        settle_block();
    endtask

    // Zero length, one, two, above depth and upper data bits ignored
    task automatic test_window_lengths();
        write_reg(wdmd_pkg::CFG_WINDOW_LENGTH, 16'd0);
        send_sample(24'h000123);
        send_sample({wdmd_pkg::MAG_W{1'b1}});
        send_sample(24'h000005);
        write_reg(wdmd_pkg::CFG_WINDOW_LENGTH, 16'hFFC1);
        send_sample(24'h555555);
        send_sample(24'hAAAAAA);
        write_reg(wdmd_pkg::CFG_WINDOW_LENGTH, 16'd2);
        send_sample('0);
        send_sample({wdmd_pkg::MAG_W{1'b1}});
        send_sample(24'h000001);
        write_reg(wdmd_pkg::CFG_WINDOW_LENGTH, 16'd33);
        send_sample(24'h0F0F0F);
        send_sample(24'hF0F0F0);
        write_reg(wdmd_pkg::CFG_WINDOW_LENGTH, 16'd63);
        send_sample(24'h7FFFFF);
        send_sample('0);
        settle_block();
    endtask

    // Threshold and hold extremes, ignored register index
    task automatic test_flag_extremes();
        write_reg(wdmd_pkg::CFG_WINDOW_LENGTH, 16'd4);
        write_reg(wdmd_pkg::CFG_MOTION_THRESHOLD, 16'd0);
        write_reg(wdmd_pkg::CFG_QUIET_HOLD, 16'd0);
        send_sample(24'h000010);
        send_sample(24'h000010);
        // Quiet sample beyond a zero hold drops the flag at once
        write_reg(wdmd_pkg::CFG_MOTION_THRESHOLD, 16'hFFFF);
        send_sample(24'h000010);
        send_sample(24'h000010);
        // Maximum hold keeps the flag up
        write_reg(wdmd_pkg::CFG_MOTION_THRESHOLD, 16'd0);
        write_reg(wdmd_pkg::CFG_QUIET_HOLD, 16'hFFFF);
        send_sample(24'h000020);
        write_reg(wdmd_pkg::CFG_MOTION_THRESHOLD, 16'hFFFF);
        send_sample(24'h000020);
        send_sample(24'h000020);
        write_reg(CFG_UNUSED_INDEX, 16'h0001);
        send_sample(24'hFFFF00);
        settle_block();
    endtask

    // Phases of random settings; bursts of motion separated by quiet stretches
    task automatic test_random_traffic();
        int                           sent;
        int                           phase_left;
        int                           seg_left;
        int                           level;
        int unsigned                  span;
        int unsigned                  jitter;
        int unsigned                  value;
        bit                           noisy;
        logic [wdmd_pkg::MAG_W-1:0]   base;
        logic [wdmd_pkg::MAG_W-1:0]   mag;
        logic [15:0]                  thr;
        logic [15:0]                  hold;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            settle_block();
            level = $urandom_range(0, 3);
            case (level)
                0: span = 16;
                1: span = 1024;
                2: span = 65536;
                default: span = 1 << wdmd_pkg::MAG_W;
            endcase
            base = wdmd_pkg::MAG_W'($urandom_range(0, (1 << wdmd_pkg::MAG_W) - 1));
            case ($urandom_range(0, 9))
                0: thr = 16'd0;
                1: thr = 16'hFFFF;
                2: thr = 16'($urandom_range(0, 16'hFFFF));
                default: thr = 16'($urandom_range(1, (span / 4 > 16'hFFFF) ? 16'hFFFF
                                                                            : span / 4));
            endcase
            case ($urandom_range(0, 9))
                0: hold = 16'hFFFE;
                1: hold = 16'hFFFF;
                2: hold = 16'($urandom_range(0, 64));
                default: hold = 16'($urandom_range(0, 8));
            endcase
            write_reg(wdmd_pkg::CFG_WINDOW_LENGTH, 16'($urandom_range(0, 16'hFFFF)));
            write_reg(wdmd_pkg::CFG_MOTION_THRESHOLD, thr);
            write_reg(wdmd_pkg::CFG_QUIET_HOLD, hold);
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED_INDEX, 16'($urandom_range(0, 16'hFFFF)));
            phase_left = $urandom_range(50, 250);
            seg_left = 0;
            noisy = 1'b0;
            jitter = 0;
            while (phase_left > 0 && sent < RANDOM_ITEMS)
            begin
                // Start a new stretch: motion or rest, with or without gaps
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(1, 40);
                    noisy = ($urandom_range(0, 1) != 0);
                    jitter = $urandom_range(0, 3);
                    gaps_on = ($urandom_range(0, 3) != 0);
                end
                if (noisy)
                begin
                    if (span == (1 << wdmd_pkg::MAG_W))
                        mag = wdmd_pkg::MAG_W'($urandom_range(0, (1 << wdmd_pkg::MAG_W) - 1));
                    else
                    begin
                        value = base + $urandom_range(0, span - 1);
                        mag = (value > {wdmd_pkg::MAG_W{1'b1}}) ? {wdmd_pkg::MAG_W{1'b1}}
                                                                : value[wdmd_pkg::MAG_W-1:0];
                    end
                end
                else
                begin
                    value = base + $urandom_range(0, jitter);
                    mag = (value > {wdmd_pkg::MAG_W{1'b1}}) ? {wdmd_pkg::MAG_W{1'b1}}
                                                            : value[wdmd_pkg::MAG_W-1:0];
                end
                send_sample(mag);
                sent++;
                seg_left--;
                phase_left--;
            end
        end
        gaps_on = 1'b1;
        settle_block();
    endtask

    initial
    begin
        for (int i = 0; i < wdmd_pkg::WINDOW_DEPTH; i++)
            window_samples[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_window_lengths();
        test_flag_extremes();
        test_random_traffic();

        // Catch any stray result after the last one
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d samples, %0d results checked, %0d register writes",
                 samples_sent, results_checked, reg_writes);
        $display("motion flag raised %0d and dropped %0d times, %0d mismatches",
                 flag_sets, flag_clears, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
